/* rtl/torg_pkg.sv */
`timescale 1ns / 1ps
// Package for the trade order risk gate: sequencer states, status codes,
// register indexes and sizes. No dependencies.
package torg_pkg;

    localparam int NUM_INSTR  = 3;
    localparam int ADDR_W     = 5;
    localparam int DIV_STEPS  = 32;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_DIV   = 6'b000100,
        S_MUL   = 6'b001000,
        S_ACC   = 6'b010000,
        S_FIN   = 6'b100000
    } t_state;

    typedef enum logic [2:0] {
        ST_ACCEPTED   = 3'd0,
        ST_ID_MISS    = 3'd1,
        ST_ZERO_VOL   = 3'd2,
        ST_UNKNOWN    = 3'd3,
        ST_OFF_TICK   = 3'd4,
        ST_FILLED     = 3'd5,
        ST_OVER_LIMIT = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        REG_TICK0    = 3'd0,
        REG_TICK1    = 3'd1,
        REG_TICK2    = 3'd2,
        REG_LIMIT0   = 3'd3,
        REG_LIMIT1   = 3'd4,
        REG_LIMIT2   = 3'd5,
        REG_MM       = 3'd6,
        REG_FIRST_ID = 3'd7
    } t_reg_idx;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_FILL   = 1'b1;
    localparam logic SIDE_BID  = 1'b0;

endpackage

/* rtl/trade_order_risk_gate_top.sv */
`timescale 1ns / 1ps
// Trade order risk gate top level: sequencer, shared restoring divider,
// position and cash state, APB register file. Depends on torg_pkg.
//
// One request at a time. An insert that passes the ID, volume and
// instrument checks with a nonzero tick runs a restoring divider over the
// price, one bit per cycle; other inserts and fills on an unknown
// instrument go straight from the checks to the result, and a fill runs
// one 32x32 multiply, then the cash update.
// A finished result sits in an output register; a new request is taken as
// soon as the sequencer is back in idle, even while that result waits.
module trade_order_risk_gate_top
    import torg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_operation,
    input  logic [31:0]         i_client_order_id,
    input  logic [2:0]          i_instrument,
    input  logic [31:0]         i_price,
    input  logic [31:0]         i_volume,
    input  logic                i_side,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [2:0]          o_status,
    output logic signed [31:0]  o_position_now,
    output logic signed [63:0]  o_cash_now,
    output logic [31:0]         o_next_order_id,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    t_state             r_state;
    logic               r_op;
    logic [31:0]        r_cid;
    logic [2:0]         r_inst;
    logic [31:0]        r_vol;
    logic               r_side;
    logic [31:0]        r_quo;
    logic [31:0]        r_rem;
    logic [CNT_W-1:0]   r_cnt;
    logic [63:0]        r_prod;
    t_status            r_status;
    logic [31:0]        r_pos_out;

    logic [31:0]        r_expected;
    logic [31:0]        r_pos [NUM_INSTR];
    logic [63:0]        r_cash;

    logic [31:0]        r_tick  [NUM_INSTR];
    logic [30:0]        r_limit [NUM_INSTR];
    logic               r_mm;
    logic [31:0]        r_first;

    logic               r_o_valid;
    t_status            r_o_status;
    logic [31:0]        r_o_pos;
    logic [63:0]        r_o_cash;
    logic [31:0]        r_o_next;

    logic               w_known;
    logic [31:0]        w_tick;
    logic [30:0]        w_limit;
    logic [31:0]        w_pos;
    logic [32:0]        w_shift;
    logic [32:0]        w_tick_ext;
    logic [31:0]        w_new_pos;
    logic [31:0]        w_mag;
    logic               w_in_acc;
    logic               w_cfg_wr;
    logic               w_out_free;
    t_reg_idx           w_idx;

    assign w_known    = (r_inst < 3'(NUM_INSTR));
    assign w_in_acc   = i_valid && !o_stall;
    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign w_out_free = !r_o_valid || !i_stall;
    assign w_idx      = t_reg_idx'(paddr[ADDR_W-1:2]);

    always_comb begin
        case (r_inst[1:0])
            2'd0: begin
                w_tick  = r_tick[0];
                w_limit = r_limit[0];
                w_pos   = r_pos[0];
            end
            2'd1: begin
                w_tick  = r_tick[1];
                w_limit = r_limit[1];
                w_pos   = r_pos[1];
            end
            2'd2: begin
                w_tick  = r_tick[2];
                w_limit = r_limit[2];
                w_pos   = r_pos[2];
            end
            default: begin
                w_tick  = 32'd1;
                w_limit = 31'd0;
                w_pos   = 32'd0;
            end
        endcase
    end

    assign w_shift    = {r_rem, r_quo[31]};
    assign w_tick_ext = {1'b0, w_tick};
    assign w_new_pos  = (r_side == SIDE_BID) ? (w_pos + r_vol) : (w_pos - r_vol);
    assign w_mag      = r_pos_out[31] ? (32'd0 - r_pos_out) : r_pos_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_o_valid  <= 1'b0;
            r_expected <= 32'd0;
            r_cash     <= 64'd0;
            r_mm       <= 1'b0;
            r_first    <= 32'd0;
            r_cnt      <= '0;
            for (int i = 0; i < NUM_INSTR; i++) begin
                r_pos[i]   <= 32'd0;
                r_tick[i]  <= 32'd1;
                r_limit[i] <= 31'd0;
            end
        end else begin
            if (r_state == S_FIN && w_out_free) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_op    <= i_operation;
                        r_cid   <= i_client_order_id;
                        r_inst  <= i_instrument;
                        r_quo   <= i_price;
                        r_vol   <= i_volume;
                        r_side  <= i_side;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_pos_out <= w_known ? w_pos : 32'd0;
                    r_rem     <= 32'd0;
                    r_cnt     <= '0;
                    if (r_op == OP_INSERT) begin
                        if (r_cid != r_expected) begin
                            r_status <= ST_ID_MISS;
                            r_state  <= S_FIN;
                        end else begin
                            r_expected <= r_expected + 32'd1;
                            if (r_vol == 32'd0) begin
                                r_status <= ST_ZERO_VOL;
                                r_state  <= S_FIN;
                            end else if (!w_known) begin
                                r_status <= ST_UNKNOWN;
                                r_state  <= S_FIN;
                            end else if (w_tick == 32'd0) begin
                                r_status <= ST_ACCEPTED;
                                r_state  <= S_FIN;
                            end else begin
                                r_state <= S_DIV;
                            end
                        end
                    end else if (!w_known) begin
                        r_status <= ST_UNKNOWN;
                        r_state  <= S_FIN;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_DIV: begin
                    if (w_shift >= w_tick_ext) begin
                        r_rem <= 32'(w_shift - w_tick_ext);
                    end else begin
                        r_rem <= w_shift[31:0];
                    end
                    r_quo <= {r_quo[30:0], 1'b0};
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                        r_state <= S_ACC;
                    end
                end
                S_MUL: begin
                    r_prod    <= 64'(r_vol) * 64'(r_quo);
                    r_pos_out <= w_new_pos;
                    for (int i = 0; i < NUM_INSTR; i++) begin
                        if (r_inst[1:0] == 2'(i)) begin
                            r_pos[i] <= w_new_pos;
                        end
                    end
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_op == OP_INSERT) begin
                        r_status <= (r_rem == 32'd0) ? ST_ACCEPTED : ST_OFF_TICK;
                    end else begin
                        r_cash <= (r_side == SIDE_BID) ? (r_cash - r_prod)
                                                       : (r_cash + r_prod);
                        r_status <= (!r_mm && (w_mag > {1'b0, w_limit}))
                                    ? ST_OVER_LIMIT : ST_FILLED;
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_o_status <= r_status;
                        r_o_pos    <= r_pos_out;
                        r_o_cash   <= r_cash;
                        r_o_next   <= r_expected;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (w_cfg_wr) begin
                unique case (w_idx)
                    REG_TICK0:    r_tick[0]  <= pwdata;
                    REG_TICK1:    r_tick[1]  <= pwdata;
                    REG_TICK2:    r_tick[2]  <= pwdata;
                    REG_LIMIT0:   r_limit[0] <= pwdata[30:0];
                    REG_LIMIT1:   r_limit[1] <= pwdata[30:0];
                    REG_LIMIT2:   r_limit[2] <= pwdata[30:0];
                    REG_MM:       r_mm       <= pwdata[0];
                    REG_FIRST_ID: begin
                        r_first    <= pwdata;
                        r_expected <= pwdata;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_TICK0:    prdata = r_tick[0];
            REG_TICK1:    prdata = r_tick[1];
            REG_TICK2:    prdata = r_tick[2];
            REG_LIMIT0:   prdata = {1'b0, r_limit[0]};
            REG_LIMIT1:   prdata = {1'b0, r_limit[1]};
            REG_LIMIT2:   prdata = {1'b0, r_limit[2]};
            REG_MM:       prdata = {31'd0, r_mm};
            REG_FIRST_ID: prdata = r_first;
            default:      prdata = 32'd0;
        endcase
    end

    assign pready          = 1'b1;
    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = r_o_valid;
    assign o_status        = r_o_status;
    assign o_position_now  = r_o_pos;
    assign o_cash_now      = r_o_cash;
    assign o_next_order_id = r_o_next;

endmodule
